// ===== rtl/rbdq_pkg.sv =====
// Package for the ring buffer deque unit: action and status codes,
// fixed field widths and the controller/datapath interface structs.
// No dependencies.
package rbdq_pkg;

  localparam int ACT_W  = 3;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 5;

  localparam logic [ACT_W-1:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [ACT_W-1:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_POP_BACK   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_PEEK_FRONT = 3'd4;
  localparam logic [ACT_W-1:0] ACT_PEEK_BACK  = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic exec;
    logic cfg_load;
  } ctl_cmd_t;

  typedef struct packed {
    logic empty;
  } dp_stat_t;

endpackage

// ===== rtl/rbdq_ctrl.sv =====
// Controller of the ring buffer deque unit: sequences accept and result
// cycles and gates configuration transfers.
// Depends on rbdq_pkg.
module rbdq_ctrl
  import rbdq_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  output logic     done,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  dp_stat_t stat,
  output ctl_cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RESP = 1'b1;

  logic state;
  logic state_next;

  always_comb begin
    case (state)
      S_IDLE:  state_next = start ? S_RESP : S_IDLE;
      S_RESP:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy         = (state == S_RESP);
  assign done         = (state == S_RESP);
  assign cfg_ready    = (state == S_IDLE) && !start;
  assign cmd.exec     = start && !busy;
  assign cmd.cfg_load = cfg_valid && cfg_ready && stat.empty;

  a_done_follows_accept: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy))
    else $error("result strobe without an accepted item");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe longer than one cycle");

endmodule

// ===== rtl/rbdq_datapath.sv =====
// Datapath of the ring buffer deque unit: slot memory, front and back
// indices, element count, capacity register and result registers.
// Depends on rbdq_pkg.
module rbdq_datapath
  import rbdq_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ctl_cmd_t              cmd,
  output dp_stat_t              stat,
  input  logic [ACT_W-1:0]      action,
  input  logic [DATA_WIDTH-1:0] push_value,
  input  logic [CNT_W-1:0]      cfg_capacity,
  output logic [DATA_WIDTH-1:0] read_value,
  output logic [STAT_W-1:0]     status,
  output logic [CNT_W-1:0]      occupancy
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMP_W = (IDX_W > CNT_W) ? IDX_W : CNT_W;
  localparam int CAP_LIMIT = (DEPTH > ((1 << CNT_W) - 1)) ? ((1 << CNT_W) - 1) : DEPTH;
  localparam logic [CNT_W-1:0] CAP_MAX = CNT_W'(CAP_LIMIT);

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] mem_q;

  logic [IDX_W-1:0]  front;
  logic [IDX_W-1:0]  back;
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  cap;
  logic              rd_hit;

  logic [IDX_W-1:0]  front_next;
  logic [IDX_W-1:0]  back_next;
  logic [CNT_W-1:0]  cnt_next;
  logic [CNT_W-1:0]  cap_next;
  logic [STAT_W-1:0] status_next;
  logic              rd_hit_next;
  logic              mem_we;
  logic [IDX_W-1:0]  waddr;
  logic [IDX_W-1:0]  raddr;

  logic is_push;
  logic is_read;
  logic at_front;
  logic full;
  logic empty;
  logic [IDX_W-1:0] seed;

  function automatic logic [IDX_W-1:0] idx_up(input logic [IDX_W-1:0] i,
                                               input logic [CNT_W-1:0] c);
    logic [CMP_W:0] nxt;
    nxt = {1'b0, CMP_W'(i)} + 1'b1;
    return (nxt >= {1'b0, CMP_W'(c)}) ? '0 : IDX_W'(nxt);
  endfunction

  function automatic logic [IDX_W-1:0] idx_down(input logic [IDX_W-1:0] i,
                                                 input logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] c_m1;
    c_m1 = c - 1'b1;
    return (i == '0) ? IDX_W'(CMP_W'(c_m1)) : i - 1'b1;
  endfunction

  assign full       = (cnt >= cap);
  assign empty      = (cnt == '0);
  assign stat.empty = empty;

  assign is_push  = (action == ACT_PUSH_FRONT) || (action == ACT_PUSH_BACK);
  assign is_read  = (action == ACT_POP_FRONT) || (action == ACT_POP_BACK) ||
                    (action == ACT_PEEK_FRONT) || (action == ACT_PEEK_BACK);
  assign at_front = (action == ACT_POP_FRONT) || (action == ACT_PEEK_FRONT);
  assign seed     = (action == ACT_PUSH_FRONT) ? front : back;
  assign raddr    = at_front ? front : back;

  always_comb begin
    front_next  = front;
    back_next   = back;
    cnt_next    = cnt;
    cap_next    = cap;
    status_next = ST_OK;
    rd_hit_next = 1'b0;
    mem_we      = 1'b0;
    waddr       = seed;
    if (cmd.exec) begin
      if (is_push) begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          mem_we   = 1'b1;
          cnt_next = cnt + 1'b1;
          if (empty) begin
            front_next = seed;
            back_next  = seed;
            waddr      = seed;
          end else if (action == ACT_PUSH_FRONT) begin
            front_next = idx_down(front, cap);
            waddr      = front_next;
          end else begin
            back_next = idx_up(back, cap);
            waddr     = back_next;
          end
        end
      end else if (is_read) begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          rd_hit_next = 1'b1;
          if (action == ACT_POP_FRONT) begin
            front_next = idx_up(front, cap);
            cnt_next   = cnt - 1'b1;
          end else if (action == ACT_POP_BACK) begin
            back_next = idx_down(back, cap);
            cnt_next  = cnt - 1'b1;
          end
        end
      end
    end else if (cmd.cfg_load) begin
      if (cfg_capacity == '0) begin
        cap_next = CNT_W'(1);
      end else if (cfg_capacity > CAP_MAX) begin
        cap_next = CAP_MAX;
      end else begin
        cap_next = cfg_capacity;
      end
      front_next = '0;
      back_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front  <= '0;
      back   <= '0;
      cnt    <= '0;
      cap    <= CAP_MAX;
      rd_hit <= 1'b0;
      status <= ST_OK;
    end else begin
      front  <= front_next;
      back   <= back_next;
      cnt    <= cnt_next;
      cap    <= cap_next;
      if (cmd.exec) begin
        rd_hit <= rd_hit_next;
        status <= status_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      occupancy <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= push_value;
    end
    if (cmd.exec && rd_hit_next) begin
      mem_q <= mem[raddr];
    end
  end

  assign read_value = rd_hit ? mem_q : '0;

  a_count_in_capacity: assert property (@(posedge clk) disable iff (rst)
    cnt <= cap)
    else $error("element count exceeds capacity");

  a_index_in_capacity: assert property (@(posedge clk) disable iff (rst)
    (CMP_W'(front) < CMP_W'(cap)) && (CMP_W'(back) < CMP_W'(cap)))
    else $error("index outside the slots in use");

  a_full_holds_count: assert property (@(posedge clk) disable iff (rst)
    cmd.exec && is_push && full |=> (status == ST_FULL) && (occupancy == $past(cnt)))
    else $error("refused push changed the occupancy");

endmodule

// ===== rtl/ring_buffer_deque_unit.sv =====
// Top level of the ring buffer deque unit: joins controller and datapath.
// Depends on rbdq_pkg, rbdq_ctrl and rbdq_datapath.
//
//   Channel   Handshake            Payload
//   command   start / busy         action, push_value
//   result    done (strobe)        read_value, status, occupancy
//   config    cfg_valid/cfg_ready  capacity
//
// For each item, the accept cycle updates the indices and count and issues
// the registered slot memory read, and the next cycle carries the result with
// done high while busy holds off the next command.
// Reset empties the deque and sets the capacity to the largest allowed value.
// The result receiver cannot stall; a configuration transfer completes in any
// idle cycle without a command and is ignored unless the deque is empty.
module ring_buffer_deque_unit
  import rbdq_pkg::*;
#(
  parameter int DEPTH      = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [ACT_W-1:0]      action,
  input  logic [DATA_WIDTH-1:0] push_value,
  output logic                  done,
  output logic [DATA_WIDTH-1:0] read_value,
  output logic [STAT_W-1:0]     status,
  output logic [CNT_W-1:0]      occupancy,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CNT_W-1:0]      capacity
);

  ctl_cmd_t cmd;
  dp_stat_t stat;

  rbdq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .done      (done),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rbdq_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .action       (action),
    .push_value   (push_value),
    .cfg_capacity (capacity),
    .read_value   (read_value),
    .status       (status),
    .occupancy    (occupancy)
  );

endmodule

// ===== verif/tb.sv =====
// Testbench for ring_buffer_deque_unit: directed and random push, pop and peek traffic
// is checked against a behavioral deque that also follows the capacity register.
// Depends on rbdq_pkg and the RTL of the unit.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rbdq_pkg::*;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int CYCLE_LIMIT = 100000;

  localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd6;
  localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [DATA_WIDTH-1:0] read_value;
    logic [STAT_W-1:0]     status;
    logic [CNT_W-1:0]      occupancy;
  } deque_reply_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  start = 1'b0;
  logic                  busy;
  logic [ACT_W-1:0]      action = ACT_PUSH_FRONT;
  logic [DATA_WIDTH-1:0] push_value = '0;
  logic                  done;
  logic [DATA_WIDTH-1:0] read_value;
  logic [STAT_W-1:0]     status;
  logic [CNT_W-1:0]      occupancy;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CNT_W-1:0]      capacity = CNT_W'(DEPTH);

  logic [DATA_WIDTH-1:0] slots [DEPTH];
  int unsigned           front_pos = 0;
  int unsigned           back_pos = 0;
  int unsigned           stored_count = 0;
  int unsigned           slot_limit = DEPTH;

  deque_reply_t awaited_replies [$];
  deque_reply_t reply_head;
  int           error_count = 0;
  int           cycle_count = 0;

  ring_buffer_deque_unit #(
    .DEPTH(DEPTH),
    .DATA_WIDTH(DATA_WIDTH)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .action(action),
    .push_value(push_value),
    .done(done),
    .read_value(read_value),
    .status(status),
    .occupancy(occupancy),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .capacity(capacity)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int unsigned step_up(int unsigned pos);
    return (pos + 1 >= slot_limit) ? 0 : pos + 1;
  endfunction

  function automatic int unsigned step_down(int unsigned pos);
    return (pos == 0) ? slot_limit - 1 : pos - 1;
  endfunction

  function automatic deque_reply_t compute_deque_reply(logic [ACT_W-1:0] act,
                                                       logic [DATA_WIDTH-1:0] val);
    deque_reply_t reply;
    logic at_front;
    reply = '0;
    at_front = (act == ACT_PUSH_FRONT || act == ACT_POP_FRONT || act == ACT_PEEK_FRONT);
    case (act)
      ACT_PUSH_FRONT, ACT_PUSH_BACK: begin
        if (stored_count >= slot_limit) begin
          reply.status = ST_FULL;
        end else begin
          if (stored_count == 0) begin
            if (at_front) back_pos = front_pos;
            else front_pos = back_pos;
          end else if (at_front) begin
            front_pos = step_down(front_pos);
          end else begin
            back_pos = step_up(back_pos);
          end
          slots[at_front ? front_pos : back_pos] = val;
          stored_count++;
        end
      end
      ACT_POP_FRONT, ACT_POP_BACK, ACT_PEEK_FRONT, ACT_PEEK_BACK: begin
        if (stored_count == 0) begin
          reply.status = ST_EMPTY;
        end else begin
          reply.read_value = slots[at_front ? front_pos : back_pos];
          if (act == ACT_POP_FRONT) begin
            front_pos = step_up(front_pos);
            stored_count--;
          end else if (act == ACT_POP_BACK) begin
            back_pos = step_down(back_pos);
            stored_count--;
          end
        end
      end
      default: ;
    endcase
    reply.occupancy = CNT_W'(stored_count);
    return reply;
  endfunction

  function automatic void take_capacity_write(logic [CNT_W-1:0] raw);
    int unsigned slots_used;
    if (stored_count != 0) return;
    slots_used = 32'(raw);
    if (slots_used == 0) slots_used = 1;
    if (slots_used > DEPTH) slots_used = DEPTH;
    slot_limit = slots_used;
    front_pos = 0;
    back_pos = 0;
  endfunction

  function automatic void note_failure(string msg);
    error_count++;
    if (error_count <= 10) $display("mismatch: %s", msg);
  endfunction

  always @(posedge clk) begin
    if (!rst && done) begin
      if (awaited_replies.size() == 0) begin
        note_failure($sformatf("unexpected result value=%h status=%0d occupancy=%0d",
                               read_value, status, occupancy));
      end else begin
        reply_head = awaited_replies.pop_front();
        if (read_value !== reply_head.read_value)
          note_failure($sformatf("read_value expected %h got %h",
                                 reply_head.read_value, read_value));
        if (status !== reply_head.status)
          note_failure($sformatf("status expected %0d got %0d", reply_head.status, status));
        if (occupancy !== reply_head.occupancy)
          note_failure($sformatf("occupancy expected %0d got %0d",
                                 reply_head.occupancy, occupancy));
      end
    end
  end

  // The start line stays high between back-to-back transfers.
  task automatic send_item(input logic [ACT_W-1:0] act, input logic [DATA_WIDTH-1:0] val,
                           input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      action <= ACT_W'($urandom);
      push_value <= $urandom;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    action <= act;
    push_value <= val;
    do @(posedge clk); while (busy);
    awaited_replies.push_back(compute_deque_reply(act, val));
  endtask

  task automatic go_idle();
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_all_results();
    go_idle();
    while (awaited_replies.size() != 0) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CNT_W-1:0] raw);
    wait_all_results();
    repeat (2) @(posedge clk);
    cfg_valid <= 1'b1;
    capacity <= raw;
    do @(posedge clk); while (!cfg_ready);
    take_capacity_write(raw);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [DATA_WIDTH-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [ACT_W-1:0] pick_action(int push_pct);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 3) return $urandom_range(0, 1) ? ACT_SPARE_HI : ACT_SPARE_LO;
    if (roll < push_pct) return $urandom_range(0, 1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
    case ($urandom_range(0, 3))
      0: return ACT_POP_FRONT;
      1: return ACT_POP_BACK;
      2: return ACT_PEEK_FRONT;
      default: return ACT_PEEK_BACK;
    endcase
  endfunction

  task automatic drain_deque(input bit with_gaps);
    while (stored_count > 0)
      send_item($urandom_range(0, 1) ? ACT_POP_BACK : ACT_POP_FRONT, pick_value(),
                with_gaps ? $urandom_range(0, 7) : 0);
  endtask

  task automatic run_random_burst(input int count, input int push_pct, input bit with_gaps);
    repeat (count) begin
      if ($urandom_range(0, 39) == 0) wait_all_results();
      send_item(pick_action(push_pct), pick_value(), with_gaps ? $urandom_range(0, 7) : 0);
    end
  endtask

  task automatic test_empty_reads();
    send_item(ACT_PEEK_FRONT, '1, 0);
    send_item(ACT_PEEK_BACK, '0, 1);
    send_item(ACT_POP_FRONT, '1, 0);
    send_item(ACT_POP_BACK, '0, 3);
  endtask

  task automatic test_basic_ops();
    send_item(ACT_PUSH_FRONT, 32'hFFFF_FFFF, 0);
    send_item(ACT_PUSH_BACK, 32'h0000_0000, 0);
    send_item(ACT_PUSH_FRONT, 32'h8000_0001, 2);
    send_item(ACT_PEEK_FRONT, '0, 0);
    send_item(ACT_PEEK_BACK, '0, 0);
    send_item(ACT_SPARE_LO, 32'h1234_5678, 1);
    send_item(ACT_SPARE_HI, 32'hFFFF_FFFF, 0);
    send_item(ACT_POP_BACK, '0, 0);
    send_item(ACT_POP_FRONT, '0, 4);
    send_item(ACT_POP_FRONT, '0, 0);
    send_item(ACT_POP_BACK, '0, 0);
  endtask

  task automatic test_capacity_limits();
    write_capacity(5'd0);
    send_item(ACT_PUSH_BACK, 32'hA5A5_5A5A, 0);
    send_item(ACT_PUSH_FRONT, 32'h5A5A_A5A5, 0);
    send_item(ACT_PEEK_BACK, '0, 0);
    // Deque is not empty here, so the write must leave the capacity at one.
    write_capacity(5'd8);
    send_item(ACT_PUSH_BACK, 32'hDEAD_0001, 0);
    send_item(ACT_POP_FRONT, '0, 0);
    send_item(ACT_POP_FRONT, '0, 0);
    write_capacity(5'd31);
    write_capacity(5'd17);
    write_capacity(5'd16);
  endtask

  task automatic test_random_traffic();
    logic [CNT_W-1:0] settings [10];
    settings = '{5'd2, 5'd16, 5'd1, 5'd3, 5'd31, 5'd0, 5'd5, 5'd17, 5'd16, 5'd0};
    settings[9] = CNT_W'($urandom_range(0, 31));
    for (int phase = 0; phase < 10; phase++) begin
      drain_deque(phase[0]);
      write_capacity(settings[phase]);
      run_random_burst(40, 80, phase[0]);
      run_random_burst(25, 25, !phase[0]);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_reads();
    test_basic_ops();
    test_capacity_limits();
    test_random_traffic();
    wait_all_results();
    repeat (4) @(posedge clk);
    if (error_count == 0 && awaited_replies.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
